[design/mts_pkg.sv]
// mts_pkg: shared constants for the minimum-tracking stack.
// Command and status codes, default sizes. No dependencies.
`timescale 1ns / 1ps

package mts_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

[design/mts_if.sv]
// mts_if: valid/ready channel interfaces for commands and results.
// Depends on mts_pkg for default widths.
`timescale 1ns / 1ps

interface mts_cmd_if
  import mts_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [WORD_BITS-1:0] data;

  modport source (output valid, output command, output data, input ready);
  modport sink   (input valid, input command, input data, output ready);
endinterface

interface mts_res_if
  import mts_pkg::*;
#(
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int COUNT_BITS = $clog2(DEPTH_DEF + 1)
);
  logic                  valid;
  logic                  ready;
  logic [WORD_BITS-1:0]  top_value;
  logic [WORD_BITS-1:0]  min_value;
  logic [COUNT_BITS-1:0] count;
  logic                  is_empty;
  logic [1:0]            status;

  modport source (output valid, output top_value, output min_value, output count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input count,
                  input is_empty, input status, output ready);
endinterface

[design/mts_mem.sv]
// mts_mem: synchronous single-write, single-read RAM, registered read data.
// Depends on mts_pkg for defaults.
`timescale 1ns / 1ps

module mts_mem
  import mts_pkg::*;
#(
  parameter int WIDTH = WORD_BITS_DEF,
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mts_ctrl.sv]
// mts_ctrl: command sequencer for the minimum-tracking stack.
// Holds counts, cached top and minimum, the result register; drives both RAMs.
// Depends on mts_pkg and mts_if.
`timescale 1ns / 1ps

module mts_ctrl
  import mts_pkg::*;
#(
  parameter int  DEPTH     = DEPTH_DEF,
  parameter int  WORD_BITS = WORD_BITS_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mts_cmd_if.sink              cmd_i,
  mts_res_if.source            res_o,
  output logic                 val_we_o,
  output logic [AW-1:0]        val_waddr_o,
  output logic                 val_re_o,
  output logic [AW-1:0]        val_raddr_o,
  input  logic [WORD_BITS-1:0] val_rdata_i,
  output logic                 min_we_o,
  output logic [AW-1:0]        min_waddr_o,
  output logic                 min_re_o,
  output logic [AW-1:0]        min_raddr_o,
  input  logic [WORD_BITS-1:0] min_rdata_i
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  logic                 state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        mcount_q, mcount_d;
  logic [WORD_BITS-1:0] top_q, top_d;
  logic [WORD_BITS-1:0] min_q, min_d;

  logic                 res_valid_q, res_valid_d;
  logic [WORD_BITS-1:0] res_top_q, res_top_d;
  logic [WORD_BITS-1:0] res_min_q, res_min_d;
  logic [CW-1:0]        res_count_q, res_count_d;
  logic [1:0]           res_status_q, res_status_d;

  logic                 accept;
  logic                 load;
  logic [1:0]           status;
  logic [CW-1:0]        count_m2;
  logic [CW-1:0]        mcount_m1;
  logic [CW-1:0]        mcount_m2;

  assign cmd_i.ready = (state_q == S_IDLE) && (!res_valid_q || res_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign count_m2    = count_q - CW'(2);
  assign mcount_m1   = mcount_q - CW'(1);
  assign mcount_m2   = mcount_q - CW'(2);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    mcount_d    = mcount_q;
    top_d       = top_q;
    min_d       = min_q;
    load        = 1'b0;
    status      = ST_OK;
    val_we_o    = 1'b0;
    val_waddr_o = count_q[AW-1:0];
    val_re_o    = 1'b0;
    val_raddr_o = count_m2[AW-1:0];
    min_we_o    = 1'b0;
    min_waddr_o = mcount_q[AW-1:0];
    min_re_o    = 1'b0;
    min_raddr_o = mcount_m1[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i.command)
            CMD_PUSH: begin
              load = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                status = ST_FULL;
              end else begin
                val_we_o = 1'b1;
                count_d  = count_q + CW'(1);
                top_d    = cmd_i.data;
                if (mcount_q == '0 || $signed(cmd_i.data) <= $signed(min_q)) begin
                  min_we_o = 1'b1;
                  mcount_d = mcount_q + CW'(1);
                  min_d    = cmd_i.data;
                end
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                load   = 1'b1;
                status = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                if (mcount_q != '0 && min_q == top_q) begin
                  mcount_d    = mcount_q - CW'(1);
                  min_raddr_o = mcount_m2[AW-1:0];
                end
                val_re_o = 1'b1;
                min_re_o = 1'b1;
                state_d  = S_FETCH;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_FETCH: begin
        top_d   = val_rdata_i;
        min_d   = min_rdata_i;
        load    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d  = res_valid_q && !res_o.ready;
    res_top_d    = res_top_q;
    res_min_d    = res_min_q;
    res_count_d  = res_count_q;
    res_status_d = res_status_q;
    if (load) begin
      res_valid_d  = 1'b1;
      res_count_d  = count_d;
      res_status_d = status;
      res_top_d    = (count_d != '0) ? top_d : '0;
      res_min_d    = (count_d != '0 && mcount_d != '0) ? min_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mcount_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mcount_q    <= mcount_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q        <= top_d;
    min_q        <= min_d;
    res_top_q    <= res_top_d;
    res_min_q    <= res_min_d;
    res_count_q  <= res_count_d;
    res_status_q <= res_status_d;
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.top_value = res_top_q;
  assign res_o.min_value = res_min_q;
  assign res_o.count     = res_count_q;
  assign res_o.is_empty  = (res_count_q == '0);
  assign res_o.status    = res_status_q;

endmodule

[design/min_tracking_stack.sv]
// min_tracking_stack: push/pop/peek stack of signed words with running minimum.
// Push, peek and rejected commands load the result register straight from the
// accepted beat; a pop that succeeds first reads both RAMs to refill the top and minimum, then loads it.
// Throughput, with the result side ready: one beat per cycle for push, peek and
// rejected commands; a pop that succeeds stalls the next beat until its read lands.
// Reset (async, active low) empties both stacks; RAM contents are left as is.
`timescale 1ns / 1ps

module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int  DEPTH     = DEPTH_DEF,
  parameter int  WORD_BITS = WORD_BITS_DEF,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mts_cmd_if.sink   cmd_i,
  mts_res_if.source res_o
);

  // Value RAM: one word per stored entry, addressed by the value count.
  logic                 val_we, val_re;
  logic [AW-1:0]        val_waddr, val_raddr;
  logic [WORD_BITS-1:0] val_rdata;

  // Minimum RAM: one word per minimum-stack entry.
  logic                 min_we, min_re;
  logic [AW-1:0]        min_waddr, min_raddr;
  logic [WORD_BITS-1:0] min_rdata;

  // The current top and minimum are cached in the sequencer, so a push or peek
  // never waits on a read. A pop reads the new top and minimum back from the
  // RAMs and holds off the next beat until they land, so no read ever overlaps
  // a write to the same entry.
  mts_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .val_we_o    (val_we),
    .val_waddr_o (val_waddr),
    .val_re_o    (val_re),
    .val_raddr_o (val_raddr),
    .val_rdata_i (val_rdata),
    .min_we_o    (min_we),
    .min_waddr_o (min_waddr),
    .min_re_o    (min_re),
    .min_raddr_o (min_raddr),
    .min_rdata_i (min_rdata)
  );

  // Data stack storage.
  mts_mem #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_val_mem (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (cmd_i.data),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  // Minimum stack storage: takes a push only when the minimum stack is empty or
  // the value is at or below the current minimum (signed compare).
  mts_mem #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_min_mem (
    .clk_i   (clk_i),
    .we_i    (min_we),
    .waddr_i (min_waddr),
    .wdata_i (cmd_i.data),
    .re_i    (min_re),
    .raddr_i (min_raddr),
    .rdata_o (min_rdata)
  );

endmodule
